FILE: hw/rtl/pgss_pkg.sv
package pgss_pkg;

  localparam int REG_COUNT = 8;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int GEAR_W = 3;
  localparam int DRIVE_W = 5;

  localparam logic [2:0] REG_UP_TARGET = 3'd0;
  localparam logic [2:0] REG_DOWN_TARGET = 3'd1;
  localparam logic [2:0] REG_REST_TARGET = 3'd2;
  localparam logic [2:0] REG_NEUTRAL_TARGET = 3'd3;
  localparam logic [2:0] REG_HALF_DOWN_TARGET = 3'd4;
  localparam logic [2:0] REG_CLUTCH_HALF = 3'd5;
  localparam logic [2:0] REG_CLUTCH_RELEASE = 3'd6;
  localparam logic [2:0] REG_PADDLE_THRESHOLD = 3'd7;

  // Reset values, register 0 in the lowest word.
  localparam logic [REG_COUNT-1:0][DATA_W-1:0] REG_RESET = {
    32'd375, 32'd0, 32'd193, 32'd230, 32'd740, 32'd532, 32'd69, 32'd952
  };

  localparam logic [3:0] MODE_HOMING = 4'd0;
  localparam logic [3:0] MODE_IDLE = 4'd1;
  localparam logic [3:0] MODE_UP = 4'd2;
  localparam logic [3:0] MODE_DOWN = 4'd3;
  localparam logic [3:0] MODE_CHECK = 4'd4;
  localparam logic [3:0] MODE_NFIRST = 4'd5;
  localparam logic [3:0] MODE_NSECOND = 4'd6;
  localparam logic [3:0] MODE_NEUTRAL = 4'd7;
  localparam logic [3:0] MODE_PADDLE = 4'd8;

  localparam int D_SDRV = 0;
  localparam int D_SUP = 1;
  localparam int D_CDRV = 2;
  localparam int D_CREL = 3;
  localparam int D_SPARK = 4;

  localparam logic [GEAR_W-1:0] DISP_NEUTRAL = 3'd7;
  localparam logic [GEAR_W-1:0] DISP_MAX_GEAR = 3'd5;

  // Paddle target is (paddle - threshold) * 385 / 120, compared scaled by 120.
  localparam int PADDLE_GAIN = 385;
  localparam int CLUTCH_SCALE = 120;
  localparam int CAPTURE_BAND = 600;
  localparam int HOLD_BAND = 13800;

  typedef struct packed {
    logic [3:0] mode;
    logic [2:0] phase;
    logic [GEAR_W-1:0] gear_count;
    logic neutral_flag;
    logic last_was_neutral;
    logic deadband_hold;
    logic [GEAR_W-1:0] display_code;
    logic [DRIVE_W-1:0] drive;
  } state_t;

  function automatic logic [GEAR_W-1:0] show_gear(input logic [GEAR_W-1:0] g);
    show_gear = (g >= 3'd1 && g <= DISP_MAX_GEAR) ? g : 3'd0;
  endfunction

  function automatic logic [GEAR_W-1:0] gear_down(input logic [GEAR_W-1:0] g);
    gear_down = (g <= 3'd1) ? 3'd1 : g - 3'd1;
  endfunction

endpackage

FILE: hw/rtl/paddle_gear_shift_sequencer_core.sv
// Paddle gear-shift sequencer. Each input word is one sample tick (three
// buttons, paddle, shifter and clutch readings) and yields exactly one output
// word with the motor, spark-cut, gear and busy bits after that tick. A word
// passes through an input register and the sequencing logic into an output
// register, so one word is taken every cycle unless output backpressure
// stalls it. The eight position registers sit at byte addresses 0, 4, ... 28
// on the APB port and should be written only while no word is in flight.
module paddle_gear_shift_sequencer_core
  import pgss_pkg::*;
#(
  parameter int POSITION_BITS = 10,
  parameter int TOP_GEAR = 5
) (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic pready,
  input  logic in_valid,
  output logic in_ready,
  input  logic up_pressed,
  input  logic down_pressed,
  input  logic neutral_pressed,
  input  logic [POSITION_BITS-1:0] paddle_sample,
  input  logic [POSITION_BITS-1:0] shift_sample,
  input  logic [POSITION_BITS-1:0] clutch_sample,
  output logic out_valid,
  input  logic out_ready,
  output logic shift_drive,
  output logic shift_dir_up,
  output logic clutch_drive,
  output logic clutch_dir_release,
  output logic spark_cut,
  output logic [GEAR_W-1:0] gear_display,
  output logic [GEAR_W-1:0] gear_number,
  output logic busy_res
);

  logic [REG_COUNT-1:0][POSITION_BITS-1:0] regs;
  logic in_full;
  logic up_q, dn_q, nt_q;
  logic [POSITION_BITS-1:0] p_q, s_q, c_q;
  state_t st, st_next;
  logic advance;

  pgss_regs #(
    .POSITION_BITS(POSITION_BITS)
  ) u_regs (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .regs(regs)
  );

  pgss_step #(
    .POSITION_BITS(POSITION_BITS),
    .TOP_GEAR(TOP_GEAR)
  ) u_step (
    .st(st),
    .up(up_q),
    .dn(dn_q),
    .nt(nt_q),
    .p(p_q),
    .s(s_q),
    .c(c_q),
    .regs(regs),
    .st_next(st_next)
  );

  assign advance = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      up_q <= up_pressed;
      dn_q <= down_pressed;
      nt_q <= neutral_pressed;
      p_q <= paddle_sample;
      s_q <= shift_sample;
      c_q <= clutch_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode <= MODE_HOMING;
      st.phase <= 3'd0;
      st.gear_count <= 3'd1;
      st.neutral_flag <= 1'b0;
      st.last_was_neutral <= 1'b0;
      st.deadband_hold <= 1'b0;
      st.display_code <= 3'd1;
      st.drive <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      shift_drive <= st_next.drive[D_SDRV];
      shift_dir_up <= st_next.drive[D_SUP];
      clutch_drive <= st_next.drive[D_CDRV];
      clutch_dir_release <= st_next.drive[D_CREL];
      spark_cut <= st_next.drive[D_SPARK];
      gear_display <= st_next.display_code;
      gear_number <= st_next.gear_count;
      busy_res <= (st_next.mode != MODE_IDLE);
    end
  end

endmodule

FILE: hw/rtl/pgss_regs.sv
module pgss_regs
  import pgss_pkg::*;
#(
  parameter int POSITION_BITS = 10
) (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic pready,
  output logic [REG_COUNT-1:0][POSITION_BITS-1:0] regs
);

  logic [2:0] index;
  logic write_en;

  assign index = paddr[ADDR_W-1:2];
  assign pready = 1'b1;
  assign write_en = psel & penable & pwrite;
  assign prdata = DATA_W'(regs[index]);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        regs[i] <= REG_RESET[i][POSITION_BITS-1:0];
      end
    end else if (write_en) begin
      regs[index] <= pwdata[POSITION_BITS-1:0];
    end
  end

endmodule

FILE: hw/rtl/pgss_step.sv
module pgss_step
  import pgss_pkg::*;
#(
  parameter int POSITION_BITS = 10,
  parameter int TOP_GEAR = 5
) (
  input  state_t st,
  input  logic up,
  input  logic dn,
  input  logic nt,
  input  logic [POSITION_BITS-1:0] p,
  input  logic [POSITION_BITS-1:0] s,
  input  logic [POSITION_BITS-1:0] c,
  input  logic [REG_COUNT-1:0][POSITION_BITS-1:0] regs,
  output state_t st_next
);

  localparam int DW = POSITION_BITS + 11;
  localparam logic [GEAR_W-1:0] TOP = GEAR_W'(TOP_GEAR);

  logic [POSITION_BITS-1:0] up_t, down_t, rest_t, neutral_t, half_down_t;
  logic [POSITION_BITS-1:0] clutch_half_t, clutch_rel_t, threshold;
  logic signed [POSITION_BITS:0] diff;
  logic signed [DW-1:0] diff_ext, gain, scale, c_ext, t, cc, d;
  logic in_capture, in_hold, check_paddle, cond;
  logic [GEAR_W-1:0] gear_tmp;

  assign up_t = regs[REG_UP_TARGET];
  assign down_t = regs[REG_DOWN_TARGET];
  assign rest_t = regs[REG_REST_TARGET];
  assign neutral_t = regs[REG_NEUTRAL_TARGET];
  assign half_down_t = regs[REG_HALF_DOWN_TARGET];
  assign clutch_half_t = regs[REG_CLUTCH_HALF];
  assign clutch_rel_t = regs[REG_CLUTCH_RELEASE];
  assign threshold = regs[REG_PADDLE_THRESHOLD];

  assign diff = $signed({1'b0, p}) - $signed({1'b0, threshold});
  assign diff_ext = DW'(diff);
  assign gain = DW'(PADDLE_GAIN);
  assign scale = DW'(CLUTCH_SCALE);
  assign c_ext = $signed({{(DW - POSITION_BITS){1'b0}}, c});
  assign t = diff_ext * gain;
  assign cc = c_ext * scale;
  assign d = t - cc;
  assign in_capture = (d < DW'(CAPTURE_BAND)) && (d > -DW'(CAPTURE_BAND));
  assign in_hold = (d < DW'(HOLD_BAND)) && (d > -DW'(HOLD_BAND));

  always_comb begin
    st_next = st;
    check_paddle = 1'b0;
    cond = 1'b0;
    gear_tmp = st.gear_count;
    unique case (st.mode)
      MODE_HOMING: begin
        if (st.phase == 3'd0) begin
          if (s < rest_t) begin
            st_next.phase = 3'd1;
            st_next.drive[D_SUP] = 1'b1;
            st_next.drive[D_SDRV] = 1'b1;
          end else if (s > rest_t) begin
            st_next.phase = 3'd2;
            st_next.drive[D_SUP] = 1'b0;
            st_next.drive[D_SDRV] = 1'b1;
          end else begin
            st_next.display_code = show_gear(st.gear_count);
            st_next.mode = MODE_IDLE;
            st_next.phase = 3'd0;
          end
        end else begin
          cond = (st.phase == 3'd1) ? (s < rest_t) : (s > rest_t);
          if (cond) begin
            st_next.drive[D_SUP] = (st.phase == 3'd1);
            st_next.drive[D_SDRV] = 1'b1;
          end else begin
            st_next.drive[D_SDRV] = 1'b0;
            st_next.display_code = show_gear(st.gear_count);
            st_next.mode = MODE_IDLE;
            st_next.phase = 3'd0;
          end
        end
      end
      MODE_IDLE: begin
        if (up && st.gear_count < TOP) begin
          st_next.mode = MODE_UP;
        end else if (dn) begin
          st_next.mode = MODE_DOWN;
        end else if (nt && !st.last_was_neutral) begin
          st_next.mode = MODE_CHECK;
        end else if (p > threshold) begin
          st_next.mode = MODE_PADDLE;
          st_next.deadband_hold = 1'b0;
        end
        st_next.phase = 3'd0;
        st_next.last_was_neutral = 1'b0;
      end
      MODE_UP: begin
        if (st.phase == 3'd0) begin
          if (!up) begin
            st_next.display_code = show_gear(st.gear_count);
            if (st.neutral_flag) begin
              st_next.phase = 3'd1;
            end else begin
              st_next.phase = 3'd2;
              st_next.drive[D_SPARK] = 1'b1;
            end
          end
        end else if (st.phase == 3'd1) begin
          if (s < neutral_t) begin
            st_next.drive[D_SUP] = 1'b1;
            st_next.drive[D_SDRV] = 1'b1;
          end else begin
            st_next.drive[D_SDRV] = 1'b0;
            st_next.phase = 3'd3;
          end
        end else if (st.phase == 3'd2) begin
          if (s < up_t) begin
            st_next.drive[D_SUP] = 1'b1;
            st_next.drive[D_SDRV] = 1'b1;
          end else begin
            st_next.drive[D_SDRV] = 1'b0;
            st_next.drive[D_SPARK] = 1'b0;
            st_next.phase = 3'd3;
          end
        end else begin
          if (s > rest_t) begin
            st_next.drive[D_SUP] = 1'b0;
            st_next.drive[D_SDRV] = 1'b1;
          end else begin
            st_next.drive[D_SDRV] = 1'b0;
            st_next.neutral_flag = 1'b0;
            if (st.gear_count < TOP) begin
              gear_tmp = st.gear_count + 3'd1;
            end
            st_next.gear_count = gear_tmp;
            st_next.display_code = show_gear(gear_tmp);
            st_next.last_was_neutral = 1'b0;
            st_next.mode = MODE_IDLE;
            st_next.phase = 3'd0;
          end
        end
      end
      MODE_DOWN: begin
        if (st.phase == 3'd0) begin
          if (!dn) begin
            st_next.display_code = show_gear(st.gear_count);
            st_next.neutral_flag = 1'b0;
            st_next.phase = 3'd1;
          end
        end else if (st.phase == 3'd1) begin
          if (c < clutch_half_t) begin
            st_next.drive[D_CREL] = 1'b0;
            st_next.drive[D_CDRV] = 1'b1;
          end else begin
            st_next.drive[D_CDRV] = 1'b0;
            st_next.phase = 3'd2;
          end
        end else if (st.phase == 3'd2) begin
          if (s > down_t) begin
            st_next.drive[D_SUP] = 1'b0;
            st_next.drive[D_SDRV] = 1'b1;
          end else begin
            st_next.drive[D_SDRV] = 1'b0;
            st_next.phase = 3'd3;
          end
        end else if (st.phase == 3'd3) begin
          if (s < rest_t) begin
            st_next.drive[D_SUP] = 1'b1;
            st_next.drive[D_SDRV] = 1'b1;
          end else begin
            st_next.drive[D_SDRV] = 1'b0;
            st_next.phase = 3'd4;
          end
        end else begin
          st_next.drive[D_CREL] = 1'b1;
          st_next.drive[D_CDRV] = 1'b1;
          if (c <= clutch_rel_t) begin
            gear_tmp = gear_down(st.gear_count);
            st_next.gear_count = gear_tmp;
            st_next.display_code = show_gear(gear_tmp);
            st_next.mode = MODE_IDLE;
            st_next.phase = 3'd0;
          end
        end
      end
      MODE_CHECK: begin
        if (!nt) begin
          st_next.phase = 3'd0;
          if (st.gear_count == 3'd1) begin
            st_next.mode = MODE_NFIRST;
          end else if (st.gear_count == 3'd2) begin
            st_next.mode = MODE_NSECOND;
          end else begin
            st_next.mode = MODE_IDLE;
          end
        end
      end
      MODE_NFIRST: begin
        if (st.phase == 3'd0) begin
          if (st.neutral_flag) begin
            st_next.mode = MODE_NEUTRAL;
            st_next.phase = 3'd0;
          end else if (s < neutral_t) begin
            st_next.drive[D_SUP] = 1'b1;
            st_next.drive[D_SDRV] = 1'b1;
          end else begin
            st_next.drive[D_SDRV] = 1'b0;
            st_next.phase = 3'd1;
          end
        end else begin
          if (s > rest_t) begin
            st_next.drive[D_SUP] = 1'b0;
            st_next.drive[D_SDRV] = 1'b1;
          end else begin
            st_next.drive[D_SDRV] = 1'b0;
            st_next.neutral_flag = 1'b1;
            st_next.mode = MODE_NEUTRAL;
            st_next.phase = 3'd0;
          end
        end
      end
      MODE_NSECOND: begin
        if (st.phase == 3'd0) begin
          if (st.neutral_flag) begin
            st_next.gear_count = gear_down(st.gear_count);
            st_next.mode = MODE_NEUTRAL;
            st_next.phase = 3'd0;
          end else if (c < clutch_half_t) begin
            st_next.drive[D_CREL] = 1'b0;
            st_next.drive[D_CDRV] = 1'b1;
          end else begin
            st_next.drive[D_CDRV] = 1'b0;
            st_next.phase = 3'd1;
          end
        end else if (st.phase == 3'd1) begin
          if (s > half_down_t) begin
            st_next.drive[D_SUP] = 1'b0;
            st_next.drive[D_SDRV] = 1'b1;
          end else begin
            st_next.drive[D_SDRV] = 1'b0;
            st_next.phase = 3'd2;
          end
        end else if (st.phase == 3'd2) begin
          if (s < rest_t) begin
            st_next.drive[D_SUP] = 1'b1;
            st_next.drive[D_SDRV] = 1'b1;
          end else begin
            st_next.drive[D_SDRV] = 1'b0;
            st_next.phase = 3'd3;
          end
        end else begin
          st_next.drive[D_CREL] = 1'b1;
          st_next.drive[D_CDRV] = 1'b1;
          if (c <= clutch_rel_t) begin
            st_next.gear_count = gear_down(st.gear_count);
            st_next.neutral_flag = 1'b1;
            st_next.mode = MODE_NEUTRAL;
            st_next.phase = 3'd0;
          end
        end
      end
      MODE_NEUTRAL: begin
        st_next.neutral_flag = 1'b1;
        st_next.display_code = DISP_NEUTRAL;
        st_next.last_was_neutral = 1'b1;
        st_next.mode = MODE_IDLE;
        st_next.phase = 3'd0;
      end
      MODE_PADDLE: begin
        if (st.deadband_hold) begin
          if (in_hold) begin
            st_next.drive[D_CDRV] = 1'b0;
          end else begin
            st_next.deadband_hold = 1'b0;
            check_paddle = 1'b1;
          end
        end else if (d == '0) begin
          st_next.mode = MODE_IDLE;
          st_next.phase = 3'd0;
        end else if (in_capture) begin
          st_next.drive[D_CDRV] = 1'b0;
          st_next.deadband_hold = 1'b1;
        end else begin
          st_next.drive[D_CREL] = d[DW-1];
          st_next.drive[D_CDRV] = 1'b1;
          check_paddle = 1'b1;
        end
        if (check_paddle && p < threshold) begin
          st_next.drive[D_CDRV] = 1'b1;
          st_next.mode = MODE_IDLE;
          st_next.phase = 3'd0;
        end
      end
      default: begin
        st_next.mode = MODE_IDLE;
        st_next.phase = 3'd0;
      end
    endcase
  end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import pgss_pkg::*;

  localparam int POS_W = 10;
  localparam int TOP_GEAR = 5;
  localparam int POS_MAX = (1 << POS_W) - 1;

  typedef struct packed {
    logic up_btn;
    logic down_btn;
    logic neutral_btn;
    logic [POS_W-1:0] paddle;
    logic [POS_W-1:0] shifter;
    logic [POS_W-1:0] clutch;
  } sample_tick_t;

  typedef struct packed {
    logic shift_drive;
    logic shift_dir_up;
    logic clutch_drive;
    logic clutch_dir_release;
    logic spark_cut;
    logic [GEAR_W-1:0] gear_display;
    logic [GEAR_W-1:0] gear_number;
    logic busy;
  } actuator_word_t;

  typedef enum {EP_UP, EP_DOWN, EP_NEUTRAL, EP_PADDLE, EP_NOISE} episode_t;
  typedef enum {SET_TYPICAL, SET_ZERO, SET_FULL, SET_RANDOM} setting_t;

  logic clk, rst;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;
  logic in_valid, in_ready, out_valid, out_ready;
  logic up_pressed, down_pressed, neutral_pressed;
  logic [POS_W-1:0] paddle_sample, shift_sample, clutch_sample;
  logic shift_drive, shift_dir_up, clutch_drive, clutch_dir_release, spark_cut, busy_res;
  logic [GEAR_W-1:0] gear_display, gear_number;

  paddle_gear_shift_sequencer_core #(.POSITION_BITS(POS_W), .TOP_GEAR(TOP_GEAR)) dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .up_pressed(up_pressed), .down_pressed(down_pressed), .neutral_pressed(neutral_pressed),
    .paddle_sample(paddle_sample), .shift_sample(shift_sample), .clutch_sample(clutch_sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .shift_drive(shift_drive), .shift_dir_up(shift_dir_up), .clutch_drive(clutch_drive),
    .clutch_dir_release(clutch_dir_release), .spark_cut(spark_cut),
    .gear_display(gear_display), .gear_number(gear_number), .busy_res(busy_res)
  );

  logic [POS_W-1:0] position_regs [REG_COUNT];
  logic [3:0] seq_mode;
  logic [2:0] seq_phase;
  logic [GEAR_W-1:0] seq_gear, shown_gear;
  logic neutral_latched, just_neutral, clutch_hold;
  logic [DRIVE_W-1:0] motor_bits;

  actuator_word_t actuator_words_due [$];
  actuator_word_t seen, due;

  int error_count, words_checked, ticks_sent, settings_used;
  int upshifts_done, downshifts_done, neutral_arrivals, paddle_captures;
  int tx_gap_max, rx_stall_max, rx_stall;
  int plant_shift, plant_clutch;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic void refresh_display();
    shown_gear = (seq_gear >= 1 && seq_gear <= DISP_MAX_GEAR) ? seq_gear : '0;
  endfunction

  function automatic void go_idle();
    seq_mode = MODE_IDLE;
    seq_phase = 0;
  endfunction

  function automatic void enter_neutral();
    neutral_latched = 1'b1;
    seq_mode = MODE_NEUTRAL;
    seq_phase = 0;
  endfunction

  function automatic void drop_gear();
    seq_gear = (seq_gear <= GEAR_W'(1)) ? GEAR_W'(1) : seq_gear - GEAR_W'(1);
  endfunction

  // The shifter is driven while run holds; a finished stroke turns the motor off.
  function automatic bit stroke(input bit run, input bit toward_up);
    if (run) begin
      motor_bits[D_SUP] = toward_up;
      motor_bits[D_SDRV] = 1'b1;
      return 1'b0;
    end
    motor_bits[D_SDRV] = 1'b0;
    return 1'b1;
  endfunction

  function automatic bit clutch_to_half(input logic [POS_W-1:0] c);
    if (c < position_regs[REG_CLUTCH_HALF]) begin
      motor_bits[D_CREL] = 1'b0;
      motor_bits[D_CDRV] = 1'b1;
      return 1'b0;
    end
    motor_bits[D_CDRV] = 1'b0;
    return 1'b1;
  endfunction

  function automatic bit clutch_let_go(input logic [POS_W-1:0] c);
    motor_bits[D_CREL] = 1'b1;
    motor_bits[D_CDRV] = 1'b1;
    return c <= position_regs[REG_CLUTCH_RELEASE];
  endfunction

  function automatic actuator_word_t advance_sequencer(input sample_tick_t t);
    actuator_word_t w;
    longint err, err_mag;
    bit check_low;
    case (seq_mode)
      MODE_HOMING: begin
        if (seq_phase == 0) begin
          if (t.shifter < position_regs[REG_REST_TARGET]) begin
            seq_phase = 1;
            void'(stroke(1'b1, 1'b1));
          end else if (t.shifter > position_regs[REG_REST_TARGET]) begin
            seq_phase = 2;
            void'(stroke(1'b1, 1'b0));
          end else begin
            refresh_display();
            go_idle();
          end
        end else if (stroke(seq_phase == 1 ? t.shifter < position_regs[REG_REST_TARGET]
                                           : t.shifter > position_regs[REG_REST_TARGET],
                            seq_phase == 1)) begin
          refresh_display();
          go_idle();
        end
      end
      MODE_IDLE: begin
        if (t.up_btn && seq_gear < TOP_GEAR) seq_mode = MODE_UP;
        else if (t.down_btn) seq_mode = MODE_DOWN;
        else if (t.neutral_btn && !just_neutral) seq_mode = MODE_CHECK;
        else if (t.paddle > position_regs[REG_PADDLE_THRESHOLD]) begin
          seq_mode = MODE_PADDLE;
          clutch_hold = 1'b0;
        end
        seq_phase = 0;
        just_neutral = 1'b0;
      end
      MODE_UP: begin
        if (seq_phase == 0) begin
          if (!t.up_btn) begin
            refresh_display();
            if (neutral_latched) seq_phase = 1;
            else begin
              seq_phase = 2;
              motor_bits[D_SPARK] = 1'b1;
            end
          end
        end else if (seq_phase == 1) begin
          if (stroke(t.shifter < position_regs[REG_NEUTRAL_TARGET], 1'b1)) seq_phase = 3;
        end else if (seq_phase == 2) begin
          if (stroke(t.shifter < position_regs[REG_UP_TARGET], 1'b1)) begin
            motor_bits[D_SPARK] = 1'b0;
            seq_phase = 3;
          end
        end else if (stroke(t.shifter > position_regs[REG_REST_TARGET], 1'b0)) begin
          neutral_latched = 1'b0;
          if (seq_gear < TOP_GEAR) seq_gear = seq_gear + GEAR_W'(1);
          refresh_display();
          just_neutral = 1'b0;
          go_idle();
          upshifts_done++;
        end
      end
      MODE_DOWN: begin
        if (seq_phase == 0) begin
          if (!t.down_btn) begin
            refresh_display();
            neutral_latched = 1'b0;
            seq_phase = 1;
          end
        end else if (seq_phase == 1) begin
          if (clutch_to_half(t.clutch)) seq_phase = 2;
        end else if (seq_phase == 2) begin
          if (stroke(t.shifter > position_regs[REG_DOWN_TARGET], 1'b0)) seq_phase = 3;
        end else if (seq_phase == 3) begin
          if (stroke(t.shifter < position_regs[REG_REST_TARGET], 1'b1)) seq_phase = 4;
        end else if (clutch_let_go(t.clutch)) begin
          drop_gear();
          refresh_display();
          go_idle();
          downshifts_done++;
        end
      end
      MODE_CHECK: begin
        if (!t.neutral_btn) begin
          seq_phase = 0;
          if (seq_gear == 1) seq_mode = MODE_NFIRST;
          else if (seq_gear == 2) seq_mode = MODE_NSECOND;
          else go_idle();
        end
      end
      MODE_NFIRST: begin
        if (seq_phase == 0) begin
          if (neutral_latched) enter_neutral();
          else if (stroke(t.shifter < position_regs[REG_NEUTRAL_TARGET], 1'b1)) seq_phase = 1;
        end else if (stroke(t.shifter > position_regs[REG_REST_TARGET], 1'b0)) begin
          enter_neutral();
        end
      end
      MODE_NSECOND: begin
        if (seq_phase == 0) begin
          if (neutral_latched) begin
            drop_gear();
            enter_neutral();
          end else if (clutch_to_half(t.clutch)) seq_phase = 1;
        end else if (seq_phase == 1) begin
          if (stroke(t.shifter > position_regs[REG_HALF_DOWN_TARGET], 1'b0)) seq_phase = 2;
        end else if (seq_phase == 2) begin
          if (stroke(t.shifter < position_regs[REG_REST_TARGET], 1'b1)) seq_phase = 3;
        end else if (clutch_let_go(t.clutch)) begin
          drop_gear();
          enter_neutral();
        end
      end
      MODE_NEUTRAL: begin
        neutral_latched = 1'b1;
        shown_gear = DISP_NEUTRAL;
        just_neutral = 1'b1;
        go_idle();
        neutral_arrivals++;
      end
      MODE_PADDLE: begin
        err = (longint'(t.paddle) - longint'(position_regs[REG_PADDLE_THRESHOLD])) * PADDLE_GAIN
              - longint'(t.clutch) * CLUTCH_SCALE;
        err_mag = (err < 0) ? -err : err;
        check_low = 1'b1;
        if (clutch_hold) begin
          if (err_mag < HOLD_BAND) begin
            motor_bits[D_CDRV] = 1'b0;
            check_low = 1'b0;
          end else clutch_hold = 1'b0;
        end else if (err == 0) begin
          go_idle();
          check_low = 1'b0;
        end else if (err_mag < CAPTURE_BAND) begin
          motor_bits[D_CDRV] = 1'b0;
          clutch_hold = 1'b1;
          check_low = 1'b0;
          paddle_captures++;
        end else begin
          motor_bits[D_CREL] = (err < 0);
          motor_bits[D_CDRV] = 1'b1;
        end
        if (check_low && t.paddle < position_regs[REG_PADDLE_THRESHOLD]) begin
          motor_bits[D_CDRV] = 1'b1;
          go_idle();
        end
      end
      default: go_idle();
    endcase
    w.shift_drive = motor_bits[D_SDRV];
    w.shift_dir_up = motor_bits[D_SUP];
    w.clutch_drive = motor_bits[D_CDRV];
    w.clutch_dir_release = motor_bits[D_CREL];
    w.spark_cut = motor_bits[D_SPARK];
    w.gear_display = shown_gear;
    w.gear_number = seq_gear;
    w.busy = (seq_mode != MODE_IDLE);
    return w;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= 20)
      $display("Mismatch at word %0d, %s: got %0d, expected %0d", words_checked, field, got,
               want);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      seen = {shift_drive, shift_dir_up, clutch_drive, clutch_dir_release, spark_cut,
              gear_display, gear_number, busy_res};
      if (actuator_words_due.size() == 0) begin
        report_mismatch("word with none pending", 1, 0);
      end else begin
        due = actuator_words_due.pop_front();
        if (seen.shift_drive !== due.shift_drive)
          report_mismatch("shift_drive", seen.shift_drive, due.shift_drive);
        if (seen.shift_dir_up !== due.shift_dir_up)
          report_mismatch("shift_dir_up", seen.shift_dir_up, due.shift_dir_up);
        if (seen.clutch_drive !== due.clutch_drive)
          report_mismatch("clutch_drive", seen.clutch_drive, due.clutch_drive);
        if (seen.clutch_dir_release !== due.clutch_dir_release)
          report_mismatch("clutch_dir_release", seen.clutch_dir_release, due.clutch_dir_release);
        if (seen.spark_cut !== due.spark_cut)
          report_mismatch("spark_cut", seen.spark_cut, due.spark_cut);
        if (seen.gear_display !== due.gear_display)
          report_mismatch("gear_display", seen.gear_display, due.gear_display);
        if (seen.gear_number !== due.gear_number)
          report_mismatch("gear_number", seen.gear_number, due.gear_number);
        if (seen.busy !== due.busy)
          report_mismatch("busy_res", seen.busy, due.busy);
      end
      words_checked++;
      rx_stall = $urandom_range(0, rx_stall_max);
    end
  end

  always @(negedge clk) begin
    if (rx_stall > 0) begin
      out_ready <= 1'b0;
      rx_stall--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_tick(input sample_tick_t t, output actuator_word_t want);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    up_pressed <= t.up_btn;
    down_pressed <= t.down_btn;
    neutral_pressed <= t.neutral_btn;
    paddle_sample <= t.paddle;
    shift_sample <= t.shifter;
    clutch_sample <= t.clutch;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    want = advance_sequencer(t);
    actuator_words_due.push_back(want);
    ticks_sent++;
  endtask

  task automatic drive_tick(input logic up_b, input logic dn_b, input logic nt_b,
                            input int p, input int s, input int c);
    sample_tick_t t;
    actuator_word_t w;
    t.up_btn = up_b;
    t.down_btn = dn_b;
    t.neutral_btn = nt_b;
    t.paddle = POS_W'(p);
    t.shifter = POS_W'(s);
    t.clutch = POS_W'(c);
    send_tick(t, w);
  endtask

  function automatic int fit_position(input int v);
    return (v < 0) ? 0 : (v > POS_MAX) ? POS_MAX : v;
  endfunction

  // Readings mostly come from a crude actuator that moves by a random step whenever
  // its motor is on, so strokes run to their targets over several ticks.
  task automatic send_plant_tick(input logic up_b, input logic dn_b, input logic nt_b,
                                 input int p, input int max_step);
    sample_tick_t t;
    actuator_word_t w;
    int step;
    t.up_btn = up_b;
    t.down_btn = dn_b;
    t.neutral_btn = nt_b;
    t.paddle = POS_W'(p);
    t.shifter = POS_W'(($urandom_range(0, 15) == 0) ? $urandom_range(0, POS_MAX)
                                                     : plant_shift);
    t.clutch = POS_W'(($urandom_range(0, 15) == 0) ? $urandom_range(0, POS_MAX)
                                                    : plant_clutch);
    send_tick(t, w);
    step = $urandom_range(1, max_step);
    if (w.shift_drive)
      plant_shift = fit_position(w.shift_dir_up ? plant_shift + step : plant_shift - step);
    if (w.clutch_drive)
      plant_clutch = fit_position(w.clutch_dir_release ? plant_clutch - step : plant_clutch + step);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (actuator_words_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input int idx, input int value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx * 4);
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    position_regs[idx] = POS_W'(value);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_register(input int idx);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_W'(idx * 4);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== {{(DATA_W-POS_W){1'b0}}, position_regs[idx]})
      report_mismatch("register readback", prdata, position_regs[idx]);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic int idle_limit();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 3;
      default: return 17;
    endcase
  endfunction

  task automatic test_register_readback();
    int i;
    for (i = 0; i < REG_COUNT; i++) check_register(i);
  endtask

  task automatic test_homing();
    drive_tick(0, 0, 0, 0, 0, 1023);
    drive_tick(0, 0, 0, 1023, 1023, 0);
  endtask

  task automatic test_upshift();
    drive_tick(1, 0, 0, 0, 532, 0);
    drive_tick(0, 0, 0, 0, 532, 0);
    drive_tick(0, 0, 0, 0, 600, 0);
    drive_tick(0, 0, 0, 0, 1023, 0);
    drive_tick(0, 0, 0, 0, 0, 0);
  endtask

  task automatic test_downshift();
    drive_tick(0, 1, 0, 0, 532, 0);
    drive_tick(0, 0, 0, 0, 532, 0);
    drive_tick(0, 0, 0, 0, 532, 0);
    drive_tick(0, 0, 0, 0, 532, 1023);
    drive_tick(0, 0, 0, 0, 0, 1023);
    drive_tick(0, 0, 0, 0, 1023, 1023);
    drive_tick(0, 0, 0, 0, 532, 0);
  endtask

  // A second neutral press right after arrival is ignored, and a search that
  // starts while already in neutral makes no motion.
  task automatic test_neutral_search();
    drive_tick(0, 0, 1, 0, 532, 0);
    drive_tick(0, 0, 0, 0, 532, 0);
    drive_tick(0, 0, 0, 0, 1023, 0);
    drive_tick(0, 0, 0, 0, 0, 0);
    drive_tick(0, 0, 0, 0, 532, 0);
    drive_tick(0, 0, 1, 0, 532, 0);
    drive_tick(0, 0, 1, 0, 532, 0);
    drive_tick(0, 0, 0, 0, 532, 0);
    drive_tick(0, 0, 0, 0, 532, 0);
    drive_tick(0, 0, 0, 0, 532, 0);
  endtask

  // With the paddle 24 counts over threshold, a clutch reading of 77 is
  // exactly on target and the paddle mode ends at once.
  task automatic test_paddle_exact_target();
    drive_tick(0, 0, 0, 1023, 532, 0);
    drive_tick(0, 0, 0, 399, 532, 77);
  endtask

  task automatic run_episode(input episode_t kind);
    sample_tick_t t;
    actuator_word_t w;
    int thr, held, n, p_hi;
    thr = position_regs[REG_PADDLE_THRESHOLD];
    if (kind == EP_NOISE) begin
      n = $urandom_range(1, 6);
      repeat (n) begin
        t.up_btn = 1'($urandom_range(0, 1));
        t.down_btn = 1'($urandom_range(0, 1));
        t.neutral_btn = 1'($urandom_range(0, 1));
        t.paddle = POS_W'($urandom_range(0, POS_MAX));
        t.shifter = POS_W'($urandom_range(0, POS_MAX));
        t.clutch = POS_W'($urandom_range(0, POS_MAX));
        send_tick(t, w);
      end
    end else if (kind == EP_PADDLE) begin
      p_hi = (thr < POS_MAX) ? thr + $urandom_range(1, POS_MAX - thr) : POS_MAX;
      send_plant_tick(0, 0, 0, p_hi, 6);
      n = 0;
      while (seq_mode != MODE_IDLE && n < 50) begin
        send_plant_tick(0, 0, 0,
                        (n < 25) ? p_hi : fit_position(p_hi + $urandom_range(0, 40) - 20), 6);
        n++;
      end
      n = 0;
      while (seq_mode != MODE_IDLE && n < 30) begin
        send_plant_tick(0, 0, 0, (thr > 0) ? $urandom_range(0, thr - 1) : 0, 200);
        n++;
      end
    end else begin
      held = $urandom_range(1, 4);
      repeat (held)
        send_plant_tick(kind == EP_UP, kind == EP_DOWN, kind == EP_NEUTRAL,
                        $urandom_range(0, thr), 200);
      n = 0;
      while (seq_mode != MODE_IDLE && n < 40) begin
        send_plant_tick(0, 0, 0, $urandom_range(0, thr), 200);
        n++;
      end
    end
  endtask

  task automatic test_random_sequences(input int n_ticks);
    int stop_at, pick;
    stop_at = ticks_sent + n_ticks;
    while (ticks_sent < stop_at) begin
      if ($urandom_range(0, 7) == 0) begin
        tx_gap_max = idle_limit();
        rx_stall_max = idle_limit();
      end
      if ($urandom_range(0, 30) == 0) wait_drained();
      pick = $urandom_range(0, 9);
      run_episode(pick < 3 ? EP_UP : pick < 5 ? EP_DOWN : pick < 7 ? EP_NEUTRAL :
                  pick < 9 ? EP_PADDLE : EP_NOISE);
    end
  endtask

  task automatic apply_setting(input setting_t s);
    int i, v, n;
    n = 0;
    while (seq_mode != MODE_IDLE && n < 40) begin
      send_plant_tick(0, 0, 0, 0, 200);
      n++;
    end
    wait_drained();
    for (i = 0; i < REG_COUNT; i++) begin
      case (s)
        SET_ZERO: v = 0;
        SET_FULL: v = POS_MAX;
        SET_RANDOM: v = $urandom_range(0, POS_MAX);
        default: begin
          case (i)
            REG_UP_TARGET: v = $urandom_range(800, 1023);
            REG_DOWN_TARGET: v = $urandom_range(0, 150);
            REG_REST_TARGET: v = $urandom_range(400, 650);
            REG_NEUTRAL_TARGET: v = $urandom_range(660, 800);
            REG_HALF_DOWN_TARGET: v = $urandom_range(160, 350);
            REG_CLUTCH_HALF: v = $urandom_range(100, 400);
            REG_CLUTCH_RELEASE: v = $urandom_range(0, 50);
            default: v = $urandom_range(200, 600);
          endcase
        end
      endcase
      write_register(i, v);
    end
    test_register_readback();
    settings_used++;
  endtask

  initial begin
    int i;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    up_pressed = 1'b0;
    down_pressed = 1'b0;
    neutral_pressed = 1'b0;
    paddle_sample = '0;
    shift_sample = '0;
    clutch_sample = '0;
    for (i = 0; i < REG_COUNT; i++) position_regs[i] = REG_RESET[i][POS_W-1:0];
    seq_mode = MODE_HOMING;
    seq_phase = 0;
    seq_gear = 1;
    shown_gear = 1;
    motor_bits = '0;
    neutral_latched = 1'b0;
    just_neutral = 1'b0;
    clutch_hold = 1'b0;
    error_count = 0;
    words_checked = 0;
    ticks_sent = 0;
    settings_used = 1;
    upshifts_done = 0;
    downshifts_done = 0;
    neutral_arrivals = 0;
    paddle_captures = 0;
    tx_gap_max = 17;
    rx_stall_max = 17;
    rx_stall = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_register_readback();
    test_homing();
    test_upshift();
    test_downshift();
    test_neutral_search();
    test_paddle_exact_target();
    plant_shift = position_regs[REG_REST_TARGET];
    plant_clutch = 0;
    test_random_sequences(300);
    apply_setting(SET_TYPICAL);
    test_random_sequences(150);
    apply_setting(SET_ZERO);
    test_random_sequences(40);
    apply_setting(SET_FULL);
    test_random_sequences(40);
    apply_setting(SET_RANDOM);
    test_random_sequences(70);

    wait_drained();
    repeat (10) @(posedge clk);
    $display("Checked %0d output words from %0d sample ticks under %0d register settings.",
             words_checked, ticks_sent, settings_used);
    $display("Upshifts %0d, downshifts %0d, neutral arrivals %0d, paddle captures %0d.",
             upshifts_done, downshifts_done, neutral_arrivals, paddle_captures);
    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/pgss_pkg.sv
hw/rtl/pgss_regs.sv
hw/rtl/pgss_step.sv
hw/rtl/paddle_gear_shift_sequencer_core.sv
sim/tb.sv
